// File: design/assert_macros.svh
// Assertion macros shared by the fuel gauge RTL.
// Included by the modules that carry concurrent checks; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define BFG_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
	else $error("fuel gauge check failed");

// Next-cycle implication, disabled while reset is asserted.
`define BFG_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
	else $error("fuel gauge check failed");

`endif

// File: design/bfg_pkg.sv
// Package of the battery fuel gauge: widths, constants, register indexes
// and the request/response structs of the serial arithmetic units. No dependencies.
`timescale 1ns / 1ps

package bfg_pkg;

	localparam int MulAW = 40;
	localparam int MulBW = 20;
	localparam int MulNW = 5;
	localparam int DivDW = 64;
	localparam int DivSW = 25;
	localparam int DivNW = 7;

	localparam logic [39:0] UC_PER_MAH = 40'd3600000;
	localparam logic [13:0] PCT_FULL   = 14'd10000;
	localparam logic [47:0] RUNTIME_MAX = 48'h7FFF_FFFF_FFFF;
	localparam logic [47:0] RUNTIME_MIN = 48'h8000_0000_0000;

	localparam logic [2:0] CFG_SCALE_A = 3'd0;
	localparam logic [2:0] CFG_SCALE_B = 3'd1;
	localparam logic [2:0] CFG_EMPTY   = 3'd2;
	localparam logic [2:0] CFG_FULL    = 3'd3;
	localparam logic [2:0] CFG_TARGET  = 3'd4;

	localparam logic [7:0]  RST_SCALE_A = 8'd40;
	localparam logic [7:0]  RST_SCALE_B = 8'd10;
	localparam logic [14:0] RST_EMPTY   = 15'd18000;
	localparam logic [14:0] RST_FULL    = 15'd25200;
	localparam logic [19:0] RST_TARGET  = 20'd20000;

	typedef struct packed {
		logic               start;
		logic               neg;
		logic [MulAW-1:0]   a;
		logic [MulBW-1:0]   b;   // aligned so the first used bit is the MSB
		logic [MulNW-1:0]   n;
	} mul_req_t;

	typedef struct packed {
		logic        done;
		logic [63:0] prod;
	} mul_rsp_t;

	typedef struct packed {
		logic               start;
		logic [DivDW-1:0]   dvd; // aligned so the first used bit is the MSB
		logic [DivSW-1:0]   dvs;
		logic [DivNW-1:0]   n;
	} div_req_t;

	typedef struct packed {
		logic             done;
		logic [DivDW-1:0] quo;
	} div_rsp_t;

endpackage

// File: design/bfg_mul.sv
// Bit-serial shift-add multiplier, one multiplier bit per cycle, sign applied at the end.
// Depends on bfg_pkg.
`timescale 1ns / 1ps

module bfg_mul (
	input  logic              clk,
	input  logic              arst_n,
	input  bfg_pkg::mul_req_t req,
	output bfg_pkg::mul_rsp_t rsp
);
	typedef enum logic [1:0] {M_IDLE, M_RUN, M_FIX} mstate_t;

	mstate_t                   state_q;
	logic [63:0]               acc_q;
	logic [bfg_pkg::MulAW-1:0] a_q;
	logic [bfg_pkg::MulBW-1:0] b_q;
	logic [bfg_pkg::MulNW-1:0] cnt_q;
	logic                      neg_q;
	logic                      done_q;
	logic [63:0]               prod_q;
	logic [63:0]               addend;

	assign addend = b_q[bfg_pkg::MulBW-1] ? {{(64-bfg_pkg::MulAW){1'b0}}, a_q} : 64'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= M_IDLE;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				M_IDLE: begin
					if (req.start) begin
						acc_q   <= 64'd0;
						a_q     <= req.a;
						b_q     <= req.b;
						cnt_q   <= req.n;
						neg_q   <= req.neg;
						state_q <= M_RUN;
					end
				end
				M_RUN: begin
					acc_q <= {acc_q[62:0], 1'b0} + addend;
					b_q   <= {b_q[bfg_pkg::MulBW-2:0], 1'b0};
					cnt_q <= cnt_q - 1'b1;
					if (cnt_q == bfg_pkg::MulNW'(1)) state_q <= M_FIX;
				end
				M_FIX: begin
					prod_q  <= neg_q ? (~acc_q + 64'd1) : acc_q;
					done_q  <= 1'b1;
					state_q <= M_IDLE;
				end
				default: state_q <= M_IDLE;
			endcase
		end
	end

	assign rsp.done = done_q;
	assign rsp.prod = prod_q;
endmodule

// File: design/bfg_div.sv
// Bit-serial restoring divider, one quotient bit per cycle.
// Depends on bfg_pkg.
`timescale 1ns / 1ps

module bfg_div (
	input  logic              clk,
	input  logic              arst_n,
	input  bfg_pkg::div_req_t req,
	output bfg_pkg::div_rsp_t rsp
);
	logic                      busy_q;
	logic                      done_q;
	logic [bfg_pkg::DivDW-1:0] dvd_q;
	logic [bfg_pkg::DivSW-1:0] dvs_q;
	logic [bfg_pkg::DivSW-1:0] rem_q;
	logic [bfg_pkg::DivNW-1:0] cnt_q;
	logic [bfg_pkg::DivSW:0]   trial;
	logic                      fits;

	assign trial = {rem_q, dvd_q[bfg_pkg::DivDW-1]};
	assign fits  = trial >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (!busy_q) begin
				if (req.start) begin
					dvd_q  <= req.dvd;
					dvs_q  <= req.dvs;
					rem_q  <= '0;
					cnt_q  <= req.n;
					busy_q <= 1'b1;
				end
			end else begin
				// shift the next dividend bit in, subtract when the divisor fits
				rem_q  <= fits ? bfg_pkg::DivSW'(trial - {1'b0, dvs_q})
				               : trial[bfg_pkg::DivSW-1:0];
				dvd_q  <= {dvd_q[bfg_pkg::DivDW-2:0], fits};
				cnt_q  <= cnt_q - 1'b1;
				if (cnt_q == bfg_pkg::DivNW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign rsp.done = done_q;
	assign rsp.quo  = dvd_q;
endmodule

// File: design/battery_fuel_gauge.sv
// Battery fuel gauge top level: sequencer, configuration registers, accumulators.
// Depends on bfg_pkg, bfg_mul, bfg_div and assert_macros.svh.
`timescale 1ns / 1ps

// One request is taken at a time and runs through a sequencer that drives one
// bit-serial multiplier (one bit per cycle) and one bit-serial divider (one
// quotient bit per cycle). Every request runs the multiplies for the two
// currents and the three powers; a request that is not a clear command also
// runs the two integration multiplies for energy and charge. A discharging
// sample that is not a clear adds the capacity product, the runtime division
// and the magnitude, difference and saturation steps. A state of charge strictly
// between the empty and full levels adds a multiply and a division. The sequencer
// waits in its output state only while the output register still holds a result
// that has not been taken. The result sits in an output register, so the next
// request is taken as soon as the sequencer is back in idle, even if the last
// result has not yet been taken. A clear command zeroes both accumulators and
// holds the runtime estimate. Configuration writes take effect at once and
// belong in idle.
module battery_fuel_gauge (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_wr_en,
	input  logic [2:0]         cfg_addr,
	input  logic [19:0]        cfg_wr_data,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic               command,
	input  logic [14:0]        bus_mv_chan_a,
	input  logic [14:0]        bus_mv_chan_b,
	input  logic signed [15:0] current_raw_chan_a,
	input  logic signed [15:0] current_raw_chan_b,
	input  logic [15:0]        elapsed_ms,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [24:0] total_current_ma,
	output logic [14:0]        avg_bus_mv,
	output logic signed [38:0] power_chan_a_uw,
	output logic signed [38:0] power_chan_b_uw,
	output logic signed [39:0] total_power_uw,
	output logic signed [63:0] energy_nj,
	output logic signed [63:0] charge_uc,
	output logic [13:0]        percent_hundredths,
	output logic               discharging,
	output logic signed [47:0] runtime_ms
);
`include "assert_macros.svh"

	typedef enum logic [4:0] {
		ST_IDLE, ST_IA, ST_IA_W, ST_IB, ST_IB_W, ST_TOT, ST_PA, ST_PA_W,
		ST_PB, ST_PB_W, ST_PT, ST_PT_W, ST_EN, ST_EN_W, ST_CH, ST_CH_W,
		ST_TG, ST_TG_W, ST_MG, ST_DF, ST_RD, ST_RD_W, ST_RSAT,
		ST_PC, ST_PC_M, ST_PC_W, ST_PD, ST_PD_W, ST_OUT
	} state_t;

	state_t state_q;

	// configuration
	logic [7:0]  scale_a_q, scale_b_q;
	logic [14:0] empty_q, full_q;
	logic [19:0] target_q;

	// captured request
	logic        cmd_q;
	logic [14:0] mva_q, mvb_q;
	logic [15:0] rawa_q, rawb_q, dt_q;

	// working values
	logic [23:0] ia_q, ib_q;
	logic [24:0] itot_q;
	logic [38:0] pa_q, pb_q;
	logic [39:0] pt_q;
	logic [63:0] energy_q, charge_q;
	logic [47:0] runtime_q;
	logic [41:0] tgt_q;
	logic [63:0] mag_q, diff_q;
	logic        over_q;
	logic [28:0] num_q;
	logic [13:0] pct_q;

	// result register
	logic        out_valid_q;
	logic [24:0] o_itot_q;
	logic [14:0] o_avg_q;
	logic [38:0] o_pa_q, o_pb_q;
	logic [39:0] o_pt_q;
	logic [63:0] o_energy_q, o_charge_q;
	logic [13:0] o_pct_q;
	logic        o_dis_q;
	logic [47:0] o_run_q;

	logic [15:0] mv_sum;
	logic [14:0] avg;
	logic [15:0] abs_rawa, abs_rawb;
	logic [23:0] abs_ia;
	logic [24:0] abs_itot;
	logic [39:0] abs_pt;
	logic [47:0] quo_lo;
	logic        quo_big_pos, quo_big_neg;

	bfg_pkg::mul_req_t mul_req;
	bfg_pkg::mul_rsp_t mul_rsp;
	bfg_pkg::div_req_t div_req;
	bfg_pkg::div_rsp_t div_rsp;

	bfg_mul u_mul (.clk(clk), .arst_n(arst_n), .req(mul_req), .rsp(mul_rsp));
	bfg_div u_div (.clk(clk), .arst_n(arst_n), .req(div_req), .rsp(div_rsp));

	assign mv_sum   = {1'b0, mva_q} + {1'b0, mvb_q};
	assign avg      = mv_sum[15:1];
	assign abs_rawa = rawa_q[15] ? (~rawa_q + 16'd1) : rawa_q;
	assign abs_rawb = rawb_q[15] ? (~rawb_q + 16'd1) : rawb_q;
	assign abs_ia   = ia_q[23] ? (~ia_q + 24'd1) : ia_q;
	assign abs_itot = itot_q[24] ? (~itot_q + 25'd1) : itot_q;
	assign abs_pt   = pt_q[39] ? (~pt_q + 40'd1) : pt_q;

	// quotient range checks for the runtime saturation
	assign quo_lo      = div_rsp.quo[47:0];
	assign quo_big_pos = |div_rsp.quo[63:47];
	assign quo_big_neg = (|div_rsp.quo[63:48]) || (div_rsp.quo[47] && |div_rsp.quo[46:0]);

	assign in_ready = (state_q == ST_IDLE);

	// issue requests to the serial units; operands are MSB-aligned for n steps
	always_comb begin
		mul_req = '0;
		div_req = '0;
		case (state_q)
			ST_IA: begin
				mul_req.start = 1'b1;
				mul_req.a     = {24'd0, abs_rawa};
				mul_req.b     = {scale_a_q, 12'd0};
				mul_req.n     = 5'd8;
				mul_req.neg   = rawa_q[15];
			end
			ST_IB: begin
				mul_req.start = 1'b1;
				mul_req.a     = {24'd0, abs_rawb};
				mul_req.b     = {scale_b_q, 12'd0};
				mul_req.n     = 5'd8;
				mul_req.neg   = rawb_q[15];
			end
			ST_PA: begin
				mul_req.start = 1'b1;
				mul_req.a     = {16'd0, abs_ia};
				mul_req.b     = {mva_q, 5'd0};
				mul_req.n     = 5'd15;
				mul_req.neg   = ia_q[23];
			end
			ST_PB: begin
				mul_req.start = 1'b1;
				mul_req.a     = {16'd0, (ib_q[23] ? (~ib_q + 24'd1) : ib_q)};
				mul_req.b     = {mvb_q, 5'd0};
				mul_req.n     = 5'd15;
				mul_req.neg   = ib_q[23];
			end
			ST_PT: begin
				mul_req.start = 1'b1;
				mul_req.a     = {15'd0, abs_itot};
				mul_req.b     = {avg, 5'd0};
				mul_req.n     = 5'd15;
				mul_req.neg   = itot_q[24];
			end
			ST_EN: begin
				mul_req.start = 1'b1;
				mul_req.a     = abs_pt;
				mul_req.b     = {dt_q, 4'd0};
				mul_req.n     = 5'd16;
				mul_req.neg   = pt_q[39];
			end
			ST_CH: begin
				mul_req.start = 1'b1;
				mul_req.a     = {15'd0, abs_itot};
				mul_req.b     = {dt_q, 4'd0};
				mul_req.n     = 5'd16;
				mul_req.neg   = itot_q[24];
			end
			ST_TG: begin
				mul_req.start = 1'b1;
				mul_req.a     = bfg_pkg::UC_PER_MAH;
				mul_req.b     = target_q;
				mul_req.n     = 5'd20;
			end
			ST_PC_M: begin
				mul_req.start = 1'b1;
				mul_req.a     = {25'd0, 15'(avg - empty_q)};
				mul_req.b     = {bfg_pkg::PCT_FULL, 6'd0};
				mul_req.n     = 5'd14;
			end
			ST_RD: begin
				div_req.start = 1'b1;
				div_req.dvd   = diff_q;
				div_req.dvs   = abs_itot;
				div_req.n     = 7'd64;
			end
			ST_PD: begin
				div_req.start = 1'b1;
				div_req.dvd   = {num_q, 35'd0};
				div_req.dvs   = {10'd0, 15'(full_q - empty_q)};
				div_req.n     = 7'd29;
			end
			default: begin
				mul_req = '0;
				div_req = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			scale_a_q   <= bfg_pkg::RST_SCALE_A;
			scale_b_q   <= bfg_pkg::RST_SCALE_B;
			empty_q     <= bfg_pkg::RST_EMPTY;
			full_q      <= bfg_pkg::RST_FULL;
			target_q    <= bfg_pkg::RST_TARGET;
			energy_q    <= 64'd0;
			charge_q    <= 64'd0;
			runtime_q   <= 48'd0;
			out_valid_q <= 1'b0;
		end else begin
			// take configuration writes; unknown indexes drop
			if (cfg_wr_en) begin
				case (cfg_addr)
					bfg_pkg::CFG_SCALE_A: scale_a_q <= cfg_wr_data[7:0];
					bfg_pkg::CFG_SCALE_B: scale_b_q <= cfg_wr_data[7:0];
					bfg_pkg::CFG_EMPTY:   empty_q   <= cfg_wr_data[14:0];
					bfg_pkg::CFG_FULL:    full_q    <= cfg_wr_data[14:0];
					bfg_pkg::CFG_TARGET:  target_q  <= cfg_wr_data;
					default: ;
				endcase
			end

			// drop the taken result; in ST_OUT the handoff below decides
			if (out_ready && state_q != ST_OUT) out_valid_q <= 1'b0;

			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						cmd_q   <= command;
						mva_q   <= bus_mv_chan_a;
						mvb_q   <= bus_mv_chan_b;
						rawa_q  <= current_raw_chan_a;
						rawb_q  <= current_raw_chan_b;
						dt_q    <= elapsed_ms;
						state_q <= ST_IA;
					end
				end
				ST_IA:   state_q <= ST_IA_W;
				ST_IA_W: begin
					if (mul_rsp.done) begin
						ia_q    <= mul_rsp.prod[23:0];
						state_q <= ST_IB;
					end
				end
				ST_IB:   state_q <= ST_IB_W;
				ST_IB_W: begin
					if (mul_rsp.done) begin
						ib_q    <= mul_rsp.prod[23:0];
						state_q <= ST_TOT;
					end
				end
				ST_TOT: begin
					itot_q  <= {ia_q[23], ia_q} + {ib_q[23], ib_q};
					state_q <= ST_PA;
				end
				ST_PA:   state_q <= ST_PA_W;
				ST_PA_W: begin
					if (mul_rsp.done) begin
						pa_q    <= mul_rsp.prod[38:0];
						state_q <= ST_PB;
					end
				end
				ST_PB:   state_q <= ST_PB_W;
				ST_PB_W: begin
					if (mul_rsp.done) begin
						pb_q    <= mul_rsp.prod[38:0];
						state_q <= ST_PT;
					end
				end
				ST_PT:   state_q <= ST_PT_W;
				ST_PT_W: begin
					if (mul_rsp.done) begin
						pt_q <= mul_rsp.prod[39:0];
						if (cmd_q) begin
							// clear: zero the accumulators, hold the runtime
							energy_q <= 64'd0;
							charge_q <= 64'd0;
							state_q  <= ST_PC;
						end else begin
							state_q <= ST_EN;
						end
					end
				end
				ST_EN:   state_q <= ST_EN_W;
				ST_EN_W: begin
					if (mul_rsp.done) begin
						energy_q <= energy_q + mul_rsp.prod;
						state_q  <= ST_CH;
					end
				end
				ST_CH:   state_q <= ST_CH_W;
				ST_CH_W: begin
					if (mul_rsp.done) begin
						charge_q <= charge_q + mul_rsp.prod;
						state_q  <= itot_q[24] ? ST_TG : ST_PC;
					end
				end
				ST_TG:   state_q <= ST_TG_W;
				ST_TG_W: begin
					if (mul_rsp.done) begin
						tgt_q   <= mul_rsp.prod[41:0];
						state_q <= ST_MG;
					end
				end
				ST_MG: begin
					mag_q   <= charge_q[63] ? (~charge_q + 64'd1) : charge_q;
					state_q <= ST_DF;
				end
				ST_DF: begin
					// remaining charge may be negative once the pack is overdrawn
					if ({22'd0, tgt_q} >= mag_q) begin
						diff_q <= {22'd0, tgt_q} - mag_q;
						over_q <= 1'b0;
					end else begin
						diff_q <= mag_q - {22'd0, tgt_q};
						over_q <= 1'b1;
					end
					state_q <= ST_RD;
				end
				ST_RD:   state_q <= ST_RD_W;
				ST_RD_W: if (div_rsp.done) state_q <= ST_RSAT;
				ST_RSAT: begin
					if (!over_q)
						runtime_q <= quo_big_pos ? bfg_pkg::RUNTIME_MAX : quo_lo;
					else
						runtime_q <= quo_big_neg ? bfg_pkg::RUNTIME_MIN : (~quo_lo + 48'd1);
					state_q <= ST_PC;
				end
				ST_PC: begin
					if (avg <= empty_q) begin
						pct_q   <= 14'd0;
						state_q <= ST_OUT;
					end else if (avg >= full_q) begin
						pct_q   <= bfg_pkg::PCT_FULL;
						state_q <= ST_OUT;
					end else begin
						state_q <= ST_PC_M;
					end
				end
				ST_PC_M: state_q <= ST_PC_W;
				ST_PC_W: begin
					if (mul_rsp.done) begin
						num_q   <= mul_rsp.prod[28:0];
						state_q <= ST_PD;
					end
				end
				ST_PD:   state_q <= ST_PD_W;
				ST_PD_W: begin
					if (div_rsp.done) begin
						pct_q   <= div_rsp.quo[13:0];
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					// hand the result to the output register once it is free
					if (!out_valid_q || out_ready) begin
						o_itot_q    <= itot_q;
						o_avg_q     <= avg;
						o_pa_q      <= pa_q;
						o_pb_q      <= pb_q;
						o_pt_q      <= pt_q;
						o_energy_q  <= energy_q;
						o_charge_q  <= charge_q;
						o_pct_q     <= pct_q;
						o_dis_q     <= itot_q[24];
						o_run_q     <= runtime_q;
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign out_valid          = out_valid_q;
	assign total_current_ma   = o_itot_q;
	assign avg_bus_mv         = o_avg_q;
	assign power_chan_a_uw    = o_pa_q;
	assign power_chan_b_uw    = o_pb_q;
	assign total_power_uw     = o_pt_q;
	assign energy_nj          = o_energy_q;
	assign charge_uc          = o_charge_q;
	assign percent_hundredths = o_pct_q;
	assign discharging        = o_dis_q;
	assign runtime_ms         = o_run_q;

	`BFG_ASSERT_IMP(a_pct_range, clk, arst_n, out_valid_q, o_pct_q <= bfg_pkg::PCT_FULL)
	`BFG_ASSERT_IMP(a_dis_sign, clk, arst_n, out_valid_q, o_dis_q == o_itot_q[24])
	`BFG_ASSERT_NXT(a_start_work, clk, arst_n, in_valid && in_ready, state_q == ST_IA)
	`BFG_ASSERT_IMP(a_unit_idle, clk, arst_n, state_q == ST_IDLE, !mul_rsp.done && !div_rsp.done)
endmodule
